### rtl/sfs_pkg.sv
`default_nettype none
package sfs_pkg;

  localparam int CountBits = 16;
  localparam int AlphaBits = 8;
  localparam int DivCntW   = $clog2(AlphaBits + 1);
  localparam logic [AlphaBits-1:0] FullAlpha = {AlphaBits{1'b1}};

  localparam int InDataW  = 40;
  localparam int InUserW  = 2;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_FADE_IN  = 2'd1,
    ACT_FADE_OUT = 2'd2,
    ACT_SET      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PH_OPAQUE    = 2'd0,
    PH_CLEAR     = 2'd1,
    PH_TO_CLEAR  = 2'd2,
    PH_TO_OPAQUE = 2'd3
  } phase_e;

  typedef struct packed {
    logic                 start;
    logic [CountBits-1:0] count;
    logic [CountBits-1:0] total;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [AlphaBits-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    phase_e               phase;
    logic                 accepted;
    logic                 draw;
    logic [AlphaBits-1:0] alpha;
  } res_t;

endpackage
`default_nettype wire

### rtl/sfs_div.sv
`default_nettype none
module sfs_div (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  sfs_pkg::div_req_t req_i,
  output sfs_pkg::div_rsp_t rsp_o
);
  import sfs_pkg::*;

  // quotient of count*255/total, one quotient bit per cycle, count < total
  logic [CountBits+AlphaBits-1:0] prod;
  logic [CountBits:0]             trial;
  logic                           qbit;
  logic [CountBits-1:0]           rem_q, div_q;
  logic [AlphaBits-1:0]           num_q, quot_q;
  logic [DivCntW-1:0]             cnt_q;
  logic                           busy_q, done_q;

  always_comb begin
    prod  = {req_i.count, {AlphaBits{1'b0}}} - {{AlphaBits{1'b0}}, req_i.count};
    trial = {rem_q, num_q[AlphaBits-1]};
    qbit  = (trial >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(AlphaBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= prod[CountBits+AlphaBits-1:AlphaBits];
      num_q <= prod[AlphaBits-1:0];
      div_q <= req_i.total;
    end else if (busy_q) begin
      rem_q  <= qbit ? CountBits'(trial - {1'b0, div_q}) : trial[CountBits-1:0];
      num_q  <= {num_q[AlphaBits-2:0], 1'b0};
      quot_q <= {quot_q[AlphaBits-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

### rtl/screen_fade_sequencer.sv
`default_nettype none
// overlay fade sequencer
// input stream: s_axis_tuser carries the action (tick, fade in, fade out, set state),
// s_axis_tdata the length, target and delay. every item gives exactly one result item
// on the output stream: alpha, draw flag, accepted flag and phase.
// commands, ticks outside a ramp and ticks that end a ramp give their result through
// the output register, and a new item can be taken every cycle while the output is free.
// a tick inside a ramp starts the bit-serial divider through a registered start, one
// quotient bit per cycle, and no item is taken until its result is ready.
// the output is a register: one more item is taken while a result waits, then the
// block holds the next result and s_axis_tready stays low until the receiver takes it.
// reset puts the overlay opaque at full alpha with no pending state change and an
// empty output register.
module screen_fade_sequencer (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // fade_length[15:0], target_state[16], delay_ticks[32:17], zero fill
  input  wire  [sfs_pkg::InDataW-1:0]   s_axis_tdata,
  // action[1:0]
  input  wire  [sfs_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // alpha[7:0], draw[8], accepted[9], phase[11:10], zero fill
  output logic [sfs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import sfs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_e;

  state_e               state_q;
  phase_e               phase_q, phase_d;
  logic                 pend_q, pend_d;
  logic                 dact_q, dact_d;
  logic [15:0]          dcnt_q, dcnt_d;
  logic [CountBits-1:0] step_q, step_d;
  logic [CountBits-1:0] total_q, total_d;
  logic [AlphaBits-1:0] opac_q, opac_d;
  logic                 need_div;
  res_t                 res_d, res_q, div_res;
  logic                 start_q;
  logic                 out_valid_q, out_valid_d, out_load, out_free, accept;
  logic [OutDataW-1:0]  out_data_q;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  action_e              act;
  logic [15:0]          in_len, in_delay;
  logic                 in_target;
  logic [AlphaBits-1:0] div_alpha;

  assign act       = action_e'(s_axis_tuser[1:0]);
  assign in_len    = s_axis_tdata[15:0];
  assign in_target = s_axis_tdata[16];
  assign in_delay  = s_axis_tdata[32:17];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    dact_d   = dact_q;
    dcnt_d   = dcnt_q;
    step_d   = step_q;
    total_d  = total_q;
    opac_d   = opac_q;
    need_div = 1'b0;
    res_d    = '0;
    unique case (act)
      ACT_TICK: begin
        if (dact_q) begin
          if (dcnt_q == '0) begin
            phase_d = pend_q ? PH_CLEAR : PH_OPAQUE;
            dact_d  = 1'b0;
          end else begin
            dcnt_d = dcnt_q - 1'b1;
          end
        end
        unique case (phase_d)
          PH_CLEAR: ;
          PH_OPAQUE: opac_d = FullAlpha;
          PH_TO_CLEAR, PH_TO_OPAQUE: begin
            step_d = step_q + 1'b1;
            // end of ramp, a zero length ends here too
            if (step_d >= total_q) begin
              if (phase_d == PH_TO_CLEAR) begin
                opac_d  = '0;
                phase_d = PH_CLEAR;
              end else begin
                opac_d  = FullAlpha;
                phase_d = PH_OPAQUE;
              end
            end else begin
              need_div = 1'b1;
            end
          end
          default: ;
        endcase
        res_d.draw = (phase_d != PH_CLEAR) && (opac_d != '0);
      end
      ACT_FADE_IN, ACT_FADE_OUT: begin
        if ((act == ACT_FADE_IN && phase_q == PH_OPAQUE) ||
            (act == ACT_FADE_OUT && phase_q == PH_CLEAR)) begin
          phase_d        = (act == ACT_FADE_IN) ? PH_TO_CLEAR : PH_TO_OPAQUE;
          step_d         = '0;
          total_d        = in_len;
          res_d.accepted = 1'b1;
        end
      end
      ACT_SET: begin
        pend_d = in_target;
        dact_d = 1'b1;
        dcnt_d = in_delay;
        if (in_delay == '0) begin
          phase_d = in_target ? PH_CLEAR : PH_OPAQUE;
        end
      end
      default: ;
    endcase
    res_d.alpha = opac_d;
    res_d.phase = phase_d;
  end

  assign div_req.start = start_q;
  assign div_req.count = step_q;
  assign div_req.total = total_q;

  sfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_alpha = (phase_q == PH_TO_CLEAR) ? FullAlpha - div_rsp.quot : div_rsp.quot;

  always_comb begin
    div_res          = '0;
    div_res.alpha    = div_alpha;
    div_res.draw     = (div_alpha != '0);
    div_res.phase    = phase_q;
  end

  // a result enters the output register, or the waiting one stays until taken
  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: out_load = accept && !need_div && out_free;
      ST_DIV:  out_load = div_rsp.done && out_free;
      ST_HOLD: out_load = out_free;
      default: ;
    endcase
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_OPAQUE;
      pend_q      <= 1'b0;
      dact_q      <= 1'b0;
      dcnt_q      <= '0;
      step_q      <= '0;
      total_q     <= '0;
      opac_q      <= FullAlpha;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q     <= (state_q == ST_IDLE) && accept && need_div;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= phase_d;
            pend_q  <= pend_d;
            dact_q  <= dact_d;
            dcnt_q  <= dcnt_d;
            step_q  <= step_d;
            total_q <= total_d;
            opac_q  <= opac_d;
            if (need_div) begin
              state_q <= ST_DIV;
            end else if (!out_free) begin
              state_q <= ST_HOLD;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            opac_q  <= div_alpha;
            state_q <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload side of the result path
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !need_div) begin
          if (out_free) begin
            out_data_q <= OutDataW'(res_d);
          end else begin
            res_q <= res_d;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (out_free) begin
            out_data_q <= OutDataW'(div_res);
          end else begin
            res_q <= div_res;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_data_q <= OutDataW'(res_q);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider result outside ramp step");
  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (!div_rsp.busy && state_q == ST_DIV))
    else $error("divider started while busy");
  a_ramp_below_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (div_rsp.quot != FullAlpha))
    else $error("ramp quotient reached full alpha");
  a_draw_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] != '0))
    else $error("draw flagged with zero alpha");
  a_accept_fading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> m_axis_tdata[11])
    else $error("accepted start without fading phase");
`endif

endmodule
`default_nettype wire
